// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the smoother RTL files.
// Expects the including module to have signals named clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is asserted.
`define RHRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that must also hold while reset is asserted.
`define RHRS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RHRS_ASSERT(lbl, prop, msg)
`define RHRS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/rhrs_pkg.sv -----
// Types, constants and helper functions for the heart-rate smoother.
// Used by the sorter, the tracker and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rhrs_pkg;

    localparam int HIST_DEPTH = 9;
    localparam int HIST_IDX_W = 4;
    localparam int PASS_W     = 3;
    localparam int RATE_W     = 8;
    localparam int RAW_W      = 10;
    localparam int TIME_W     = 32;
    localparam int IVAL_W     = 16;
    localparam int REP_W      = 3;
    localparam int SEED_CNT_W = 2;

    typedef logic [RATE_W-1:0]     rate_t;
    typedef logic [HIST_IDX_W-1:0] hidx_t;
    typedef logic [PASS_W-1:0]     pass_t;
    typedef logic [REP_W-1:0]      rep_t;

    // Sorter sequencing: one bubble pass is HIST_DEPTH-1 compares plus one rotate.
    localparam hidx_t LAST_STEP = hidx_t'(HIST_DEPTH - 1);
    localparam pass_t LAST_PASS = pass_t'(HIST_DEPTH - 2);
    localparam hidx_t MID_LO    = hidx_t'(2);
    localparam hidx_t MID_HI    = hidx_t'(6);

    // Sum of five middle entries and its division by five via reciprocal.
    localparam int SUM5_W     = 11;
    localparam int DIV5_MUL_W = 12;
    localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 12'd3277;
    localparam int DIV5_SHIFT = 14;

    // Sum of three seed averages and its division by three.
    localparam int SUM3_W     = 10;
    localparam int DIV3_MUL_W = 10;
    localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 10'd683;
    localparam int DIV3_SHIFT = 11;

    localparam rep_t REP_MAX = 3'd7;
    localparam rep_t REP_ONE = 3'd1;
    localparam logic [SEED_CNT_W-1:0] SEED_LAST = 2'd2;

    typedef enum logic [2:0] {
        CFG_MIN_VALID   = 3'd0,
        CFG_MAX_VALID   = 3'd1,
        CFG_SEED_TOL    = 3'd2,
        CFG_CHANGE_LIM  = 3'd3,
        CFG_CAND_TOL    = 3'd4,
        CFG_CONFIRM     = 3'd5,
        CFG_MAX_STEP    = 3'd6,
        CFG_INTERVAL    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        rate_t              min_valid;
        rate_t              max_valid;
        rate_t              seed_tol;
        rate_t              change_limit;
        rate_t              cand_tol;
        rep_t               confirm;
        rate_t              max_step;
        logic [IVAL_W-1:0]  interval;
    } rhrs_cfg_t;

    localparam rhrs_cfg_t CFG_RESET = '{
        min_valid:    8'd30,
        max_valid:    8'd220,
        seed_tol:     8'd12,
        change_limit: 8'd12,
        cand_tol:     8'd10,
        confirm:      3'd3,
        max_step:     8'd4,
        interval:     16'd1000
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SORT,
        ST_UPDATE,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        SRT_IDLE,
        SRT_PASS,
        SRT_SUM,
        SRT_DIV,
        SRT_DONE
    } sort_state_t;

    function automatic rate_t absdiff(input rate_t a, input rate_t b);
        absdiff = (a > b) ? (a - b) : (b - a);
    endfunction

    // Move cur toward tgt by at most step.
    function automatic rate_t approach(input rate_t cur, input rate_t tgt, input rate_t step);
        if (tgt > cur && (tgt - cur) > step)
            approach = cur + step;
        else if (cur > tgt && (cur - tgt) > step)
            approach = cur - step;
        else
            approach = tgt;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rhrs_sorter.sv -----
// Trimmed-mean unit: bubble sort over a rotating nine-entry line, then the
// middle five are summed and divided by five. Depends on rhrs_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rhrs_sorter
    import rhrs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  rate_t vals [HIST_DEPTH],
    output logic  done,
    output rate_t avg
);

    sort_state_t state_reg, state_next;
    rate_t       w_reg [HIST_DEPTH];
    hidx_t       step_reg;
    pass_t       pass_reg;
    logic [SUM5_W-1:0] sum_reg;
    rate_t       avg_reg;

    rate_t lo, hi;
    logic [SUM5_W+DIV5_MUL_W-1:0] prod;

    // The single compare unit always looks at the two head taps.
    assign lo   = (w_reg[1] < w_reg[0]) ? w_reg[1] : w_reg[0];
    assign hi   = (w_reg[1] < w_reg[0]) ? w_reg[0] : w_reg[1];
    assign prod = (SUM5_W+DIV5_MUL_W)'(sum_reg) * (SUM5_W+DIV5_MUL_W)'(DIV5_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= SRT_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        done       = 1'b0;
        unique case (state_reg)
            SRT_IDLE:
            begin
                if (start)
                    state_next = SRT_PASS;
            end
            SRT_PASS:
            begin
                if (step_reg == LAST_STEP && pass_reg == LAST_PASS)
                    state_next = SRT_SUM;
            end
            SRT_SUM:
            begin
                if (step_reg == MID_HI)
                    state_next = SRT_DIV;
            end
            SRT_DIV:
            begin
                state_next = SRT_DONE;
            end
            SRT_DONE:
            begin
                done       = 1'b1;
                state_next = SRT_IDLE;
            end
            default:
            begin
                state_next = SRT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            pass_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                SRT_IDLE:
                begin
                    step_reg <= '0;
                    pass_reg <= '0;
                end
                SRT_PASS:
                begin
                    if (step_reg == LAST_STEP)
                    begin
                        step_reg <= '0;
                        pass_reg <= pass_reg + pass_t'(1);
                    end
                    else
                        step_reg <= step_reg + hidx_t'(1);
                end
                SRT_SUM:
                begin
                    step_reg <= step_reg + hidx_t'(1);
                end
                default:
                begin
                    step_reg <= '0;
                end
            endcase
        end
    end

    // A compare step keeps the larger value at the head and sends the smaller
    // to the tail; the last step of a pass only rotates, which puts the pass
    // maximum at the tail and leaves the line in plain bubble-sort order.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            SRT_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < HIST_DEPTH; i++)
                        w_reg[i] <= vals[i];
                end
                sum_reg <= '0;
            end
            SRT_PASS:
            begin
                if (step_reg == LAST_STEP)
                begin
                    for (int i = 0; i < HIST_DEPTH - 1; i++)
                        w_reg[i] <= w_reg[i+1];
                    w_reg[HIST_DEPTH-1] <= w_reg[0];
                end
                else
                begin
                    w_reg[0] <= hi;
                    for (int i = 1; i < HIST_DEPTH - 1; i++)
                        w_reg[i] <= w_reg[i+1];
                    w_reg[HIST_DEPTH-1] <= lo;
                end
            end
            SRT_SUM:
            begin
                for (int i = 0; i < HIST_DEPTH - 1; i++)
                    w_reg[i] <= w_reg[i+1];
                w_reg[HIST_DEPTH-1] <= w_reg[0];
                if (step_reg >= MID_LO)
                    sum_reg <= sum_reg + SUM5_W'(w_reg[0]);
            end
            SRT_DIV:
            begin
                avg_reg <= prod[DIV5_SHIFT +: RATE_W];
            end
            default:
            begin
                sum_reg <= sum_reg;
            end
        endcase
    end

    assign avg = avg_reg;

    `RHRS_ASSERT(a_done_single, done |=> !done, "sorter done lasted more than one cycle")
    `RHRS_ASSERT(a_start_clears, (start && state_reg == SRT_IDLE) |=> (step_reg == '0 && pass_reg == '0), "sorter counters not cleared on start")
    `RHRS_ASSERT(a_step_range, step_reg <= LAST_STEP, "sorter step counter out of range")

endmodule

`default_nettype wire

// ----- rtl/core/rhrs_tracker.sv -----
// Stable-rate tracker: seeding from three averages, slew-limited following
// and candidate confirmation for large changes. Depends on rhrs_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rhrs_tracker
    import rhrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      clear,
    input  logic      update,
    input  rate_t     avg,
    input  rhrs_cfg_t cfg,
    output logic      present,
    output rate_t     value
);

    logic                  present_reg, present_next;
    rate_t                 value_reg, value_next;
    logic [SEED_CNT_W-1:0] seed_cnt_reg, seed_cnt_next;
    rate_t                 seed0_reg, seed0_next;
    rate_t                 seed1_reg, seed1_next;
    rate_t                 cand_reg, cand_next;
    logic                  cand_p_reg, cand_p_next;
    rep_t                  rep_reg, rep_next;

    rate_t              seed_lo, seed_hi, seed_mean;
    logic [SUM3_W-1:0]  seed_sum;
    logic [SUM3_W+DIV3_MUL_W-1:0] seed_prod;
    logic               near;
    rate_t              target, stepped;
    rep_t               rep_inc;

    always_comb
    begin
        seed_lo = seed0_reg;
        seed_hi = seed0_reg;
        if (seed1_reg < seed_lo) seed_lo = seed1_reg;
        if (seed1_reg > seed_hi) seed_hi = seed1_reg;
        if (avg < seed_lo) seed_lo = avg;
        if (avg > seed_hi) seed_hi = avg;
    end

    assign seed_sum  = SUM3_W'(seed0_reg) + SUM3_W'(seed1_reg) + SUM3_W'(avg);
    assign seed_prod = (SUM3_W+DIV3_MUL_W)'(seed_sum) * (SUM3_W+DIV3_MUL_W)'(DIV3_MUL);
    assign seed_mean = seed_prod[DIV3_SHIFT +: RATE_W];

    // One approach unit serves both the direct follow and the confirmed move.
    assign near    = absdiff(avg, value_reg) <= cfg.change_limit;
    assign target  = near ? avg : cand_reg;
    assign stepped = approach(value_reg, target, cfg.max_step);
    assign rep_inc = (rep_reg == REP_MAX) ? REP_MAX : rep_reg + REP_ONE;

    always_comb
    begin
        present_next  = present_reg;
        value_next    = value_reg;
        seed_cnt_next = seed_cnt_reg;
        seed0_next    = seed0_reg;
        seed1_next    = seed1_reg;
        cand_next     = cand_reg;
        cand_p_next   = cand_p_reg;
        rep_next      = rep_reg;

        priority if (clear)
        begin
            present_next  = 1'b0;
            value_next    = '0;
            seed_cnt_next = '0;
            cand_next     = '0;
            cand_p_next   = 1'b0;
            rep_next      = '0;
        end
        else if (update && !present_reg)
        begin
            if (seed_cnt_reg == '0)
            begin
                seed0_next    = avg;
                seed_cnt_next = seed_cnt_reg + 2'd1;
            end
            else if (seed_cnt_reg != SEED_LAST)
            begin
                seed1_next    = avg;
                seed_cnt_next = seed_cnt_reg + 2'd1;
            end
            else if ((seed_hi - seed_lo) <= cfg.seed_tol)
            begin
                value_next    = seed_mean;
                present_next  = 1'b1;
                seed_cnt_next = '0;
                cand_next     = '0;
                cand_p_next   = 1'b0;
                rep_next      = '0;
            end
            else
            begin
                // Spread too wide: drop the oldest and wait for one more.
                seed0_next    = seed1_reg;
                seed1_next    = avg;
                seed_cnt_next = SEED_LAST;
            end
        end
        else if (update)
        begin
            if (near)
            begin
                value_next  = stepped;
                cand_next   = '0;
                cand_p_next = 1'b0;
                rep_next    = '0;
            end
            else if (!cand_p_reg || absdiff(avg, cand_reg) > cfg.cand_tol)
            begin
                cand_next   = avg;
                cand_p_next = 1'b1;
                rep_next    = REP_ONE;
            end
            else if (rep_inc >= cfg.confirm)
            begin
                value_next = stepped;
                if (absdiff(stepped, cand_reg) <= cfg.change_limit)
                begin
                    cand_next   = '0;
                    cand_p_next = 1'b0;
                    rep_next    = '0;
                end
                else
                    rep_next = cfg.confirm;
            end
            else
                rep_next = rep_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg  <= 1'b0;
            value_reg    <= '0;
            seed_cnt_reg <= '0;
            seed0_reg    <= '0;
            seed1_reg    <= '0;
            cand_reg     <= '0;
            cand_p_reg   <= 1'b0;
            rep_reg      <= '0;
        end
        else
        begin
            present_reg  <= present_next;
            value_reg    <= value_next;
            seed_cnt_reg <= seed_cnt_next;
            seed0_reg    <= seed0_next;
            seed1_reg    <= seed1_next;
            cand_reg     <= cand_next;
            cand_p_reg   <= cand_p_next;
            rep_reg      <= rep_next;
        end
    end

    assign present = present_reg;
    assign value   = value_reg;

    `RHRS_ASSERT(a_seed_idle, present_reg |-> (seed_cnt_reg == '0), "seed count left over after seeding")
    `RHRS_ASSERT(a_seed_range, seed_cnt_reg != 2'd3, "seed count past three")
    `RHRS_ASSERT(a_no_cand, !cand_p_reg |-> (rep_reg == '0 && cand_reg == '0), "stale candidate state")
    `RHRS_ASSERT(a_clear, clear |=> (!present_reg && !cand_p_reg), "clear did not drop stable rate")

endmodule

`default_nettype wire

// ----- rtl/core/robust_heart_rate_smoother.sv -----
// Top level of the robust heart-rate smoother: configuration registers,
// reading history, control sequencer and output register. Depends on
// rhrs_pkg, rhrs_sorter and rhrs_tracker.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Robust heart-rate smoother. Each input beat carries either a raw reading
// with a millisecond timestamp or a clear command (tuser bit 0 set). Readings
// inside [min_valid_rate, max_valid_rate] go into a nine-entry history ring.
// Once the ring is full and at least update_interval_ms has passed since the
// last update, the history is sorted and the middle five readings are
// averaged; that average seeds or moves the stable rate. Every input beat
// produces exactly one output beat. A beat that causes no update moves the
// sequencer from idle to the emit state, which loads its result into the
// output register and returns to idle, where the next input beat can be
// taken. A beat that triggers an update passes through the load, sort,
// update and emit states: the sorter copies the history, and its single
// compare unit makes eight bubble passes of nine steps over the rotating
// history, followed by seven summing steps and one divide step; the sorter
// then raises its done flag, the tracker takes the average in the update
// state, and the emit state loads the result into the output register.
// The input side is not ready while a beat is being worked on. A finished
// result sits in the output register, and the next input beat can be taken
// while it waits there; that beat's result then waits, with the input side
// not ready, until the sink takes the earlier one. Configuration writes are
// taken every cycle and must only be made while the block is idle.

module robust_heart_rate_smoother
    import rhrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [9:0] raw_rate, [41:10] now_ms, rest zero
    input  logic [0:0]  s_axis_tuser,   // [0] action (1 = clear)

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] stable_rate
    output logic [1:0]  m_axis_tuser,   // [0] rate_valid, [1] reading_accepted

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration registers.
    rhrs_cfg_t cfg_reg;

    // Input beat fields.
    logic              in_action;
    logic [RAW_W-1:0]  in_raw;
    logic [TIME_W-1:0] in_now;
    logic              in_accept;
    logic              in_range;
    logic              full_after;
    logic              due;
    logic [TIME_W-1:0] elapsed;

    // History and its bookkeeping.
    rate_t             hist_reg [HIST_DEPTH];
    hidx_t             wr_idx_reg;
    hidx_t             fill_reg;
    logic [TIME_W-1:0] last_upd_reg;
    logic              acc_reg;

    // Sequencer.
    ctrl_state_t state_reg, state_next;
    logic        sort_start;
    logic        trk_update;
    logic        trk_clear;
    logic        emit_load;

    // Sorter and tracker results.
    logic  sort_done;
    rate_t sort_avg;
    logic  trk_present;
    rate_t trk_value;

    // Output register.
    logic        m_valid_reg;
    rate_t       m_data_reg;
    logic [1:0]  m_user_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MIN_VALID:  cfg_reg.min_valid    <= cfg_data[RATE_W-1:0];
                CFG_MAX_VALID:  cfg_reg.max_valid    <= cfg_data[RATE_W-1:0];
                CFG_SEED_TOL:   cfg_reg.seed_tol     <= cfg_data[RATE_W-1:0];
                CFG_CHANGE_LIM: cfg_reg.change_limit <= cfg_data[RATE_W-1:0];
                CFG_CAND_TOL:   cfg_reg.cand_tol     <= cfg_data[RATE_W-1:0];
                CFG_CONFIRM:    cfg_reg.confirm      <= cfg_data[REP_W-1:0];
                CFG_MAX_STEP:   cfg_reg.max_step     <= cfg_data[RATE_W-1:0];
                CFG_INTERVAL:   cfg_reg.interval     <= cfg_data[IVAL_W-1:0];
                default:        cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign in_action = s_axis_tuser[0];
    assign in_raw    = s_axis_tdata[RAW_W-1:0];
    assign in_now    = s_axis_tdata[RAW_W +: TIME_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // An accepted reading is at most max_valid_rate, so it always fits the
    // eight-bit history entries.
    assign in_range   = (in_raw >= RAW_W'(cfg_reg.min_valid)) &&
                        (in_raw <= RAW_W'(cfg_reg.max_valid));
    assign full_after = (fill_reg >= hidx_t'(HIST_DEPTH - 1));
    assign elapsed    = in_now - last_upd_reg;
    assign due        = (elapsed >= TIME_W'(cfg_reg.interval));

    // History contents need no reset: the fill count gates every read.
    always_ff @(posedge clk)
    begin
        if (in_accept && !in_action && in_range)
            hist_reg[wr_idx_reg] <= in_raw[RATE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg   <= '0;
            fill_reg     <= '0;
            last_upd_reg <= '0;
            acc_reg      <= 1'b0;
        end
        else if (in_accept)
        begin
            acc_reg <= !in_action && in_range;
            if (in_action)
            begin
                wr_idx_reg   <= '0;
                fill_reg     <= '0;
                last_upd_reg <= '0;
            end
            else if (in_range)
            begin
                wr_idx_reg <= (wr_idx_reg == LAST_STEP) ? '0 : wr_idx_reg + hidx_t'(1);
                if (fill_reg != hidx_t'(HIST_DEPTH))
                    fill_reg <= fill_reg + hidx_t'(1);
                if (full_after && due)
                    last_upd_reg <= in_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // The history is copied into the sorter in the load state that follows the
    // accepting edge, so the reading just written is part of the sort.
    always_comb
    begin
        state_next = state_reg;
        sort_start = 1'b0;
        trk_update = 1'b0;
        emit_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (!in_action && in_range && full_after && due)
                        state_next = ST_LOAD;
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_LOAD:
            begin
                sort_start = 1'b1;
                state_next = ST_SORT;
            end
            ST_SORT:
            begin
                if (sort_done)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                trk_update = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    emit_load  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign trk_clear = in_accept && in_action;

    rhrs_sorter u_sorter (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sort_start),
        .vals  (hist_reg),
        .done  (sort_done),
        .avg   (sort_avg)
    );

    rhrs_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (trk_clear),
        .update  (trk_update),
        .avg     (sort_avg),
        .cfg     (cfg_reg),
        .present (trk_present),
        .value   (trk_value)
    );

    // Output register: holds one result beat until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (emit_load)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            m_data_reg <= trk_present ? trk_value : '0;
            m_user_reg <= {acc_reg, trk_present};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    `RHRS_ASSERT_ALWAYS(a_fill_range, fill_reg <= hidx_t'(HIST_DEPTH), "history fill count past depth")
    `RHRS_ASSERT_ALWAYS(a_idx_range, wr_idx_reg <= LAST_STEP, "history write index past depth")
    `RHRS_ASSERT(a_sort_full, sort_start |-> (fill_reg == hidx_t'(HIST_DEPTH)), "sort started on a partly filled history")
    `RHRS_ASSERT(a_busy_after, in_accept |=> !s_axis_tready, "input ready right after an accepted beat")
    `RHRS_ASSERT(a_no_overrun, emit_load |-> (!m_valid_reg || m_axis_tready), "output register overwritten before it was taken")

endmodule

`default_nettype wire
